// ===== design/assert_macros.svh =====
// Assertion macros shared by the bounded vector store RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define AST_CHECK(lbl, clk_s, rstn_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
		else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define AST_NEVER(lbl, clk_s, rstn_s, cond, msg) \
	`AST_CHECK(lbl, clk_s, rstn_s, !(cond), msg)

`endif

// ===== design/bvs_pkg.sv =====
// Shared constants, payload types and RAM port type for the bounded vector store.
// Depends on nothing; used by bvs_ram and bounded_vector_store.
package bvs_pkg;

	localparam int DEPTH = 256;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int DW    = 32;
	localparam int PW    = 10;

	localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);
	localparam logic [CW-1:0] COUNT_ONE  = CW'(1);

	localparam logic signed [DW-1:0] FILL_RESET = 32'sd123456;

	localparam logic [2:0] OP_PUSH    = 3'd0;
	localparam logic [2:0] OP_GET     = 3'd1;
	localparam logic [2:0] OP_SET     = 3'd2;
	localparam logic [2:0] OP_REVERSE = 3'd3;
	localparam logic [2:0] OP_DELETE  = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [2:0]           operation;
		logic [PW-1:0]        position;
		logic signed [DW-1:0] word_in;
	} req_t;

	typedef struct packed {
		logic signed [DW-1:0] read_word;
		logic [1:0]           status;
		logic [CW-1:0]        count_now;
	} rsp_t;

	typedef struct packed {
		logic                 we;
		logic [AW-1:0]        waddr;
		logic signed [DW-1:0] wdata;
		logic                 re;
		logic [AW-1:0]        raddr;
	} ram_cmd_t;

endpackage

// ===== design/bvs_ram.sv =====
// Word store: one write port and one read port, read data registered.
// Depends on bvs_pkg for depth, widths and the command struct.
module bvs_ram (
	input  logic                         clk,
	input  bvs_pkg::ram_cmd_t            cmd,
	output logic signed [bvs_pkg::DW-1:0] rd_data
);

	logic signed [bvs_pkg::DW-1:0] mem_q [bvs_pkg::DEPTH];
	logic signed [bvs_pkg::DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem_q[cmd.waddr] <= cmd.wdata;
		end
		if (cmd.re) begin
			rd_data_q <= mem_q[cmd.raddr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/bounded_vector_store.sv =====
// Top level of the bounded vector store: sequencer, count, fill register, result register.
// Depends on bvs_pkg, bvs_ram and assert_macros.svh.
//
// Usage: a fixed-capacity vector of signed 32-bit words. Requests arrive on the
// req channel (valid/ready, payload req_t) and each one answers with exactly one
// item on the rsp channel (valid/ready, payload rsp_t). cfg_wen/cfg_wdata set the
// word that delete writes into freed tail slots; write it only while idle.
// An accepted request's result is held in the pending register and moves on to the
// result register, which drives rsp, once that is free. Push, get and set stream
// at one item per cycle while rsp drains. Reverse swaps floor(count/2) pairs, each
// through S_REV_HI, S_REV_WLO and S_REV_WHI, since each pair needs two reads on the
// single RAM read port. Delete streams the count entries through the read port at
// one per cycle, then writes one fill word per removed entry.
// Reset clears the count and restores the fill word to 123456; the RAM contents
// are not cleared and are only read below the count, which is always written.
// When the receiver stalls, the result waits in the output register; one more
// request is still taken and held in the sequencer until the register frees.
`include "assert_macros.svh"

module bounded_vector_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  bvs_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output bvs_pkg::rsp_t                 rsp,
	input  logic                          cfg_wen,
	input  logic signed [bvs_pkg::DW-1:0] cfg_wdata
);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_DONE     = 7'b0000010,
		S_REV_HI   = 7'b0000100,
		S_REV_WLO  = 7'b0001000,
		S_REV_WHI  = 7'b0010000,
		S_DEL_SCAN = 7'b0100000,
		S_DEL_FILL = 7'b1000000
	} state_t;

	state_t                        state_q, state_d;
	logic [bvs_pkg::CW-1:0]        count_q;
	logic signed [bvs_pkg::DW-1:0] fill_q;
	logic                          out_valid_q;
	bvs_pkg::rsp_t                 out_q;
	bvs_pkg::rsp_t                 pend_q, pend_d;
	logic                          get_ok_q;
	logic [bvs_pkg::AW-1:0]        lo_q, hi_q, lo_nx, hi_nx;
	logic signed [bvs_pkg::DW-1:0] tmp_q;
	logic [bvs_pkg::CW-1:0]        rd_q, wr_q;
	logic                          vld_s1;
	logic signed [bvs_pkg::DW-1:0] del_val_q;

	logic                          out_free, acc, full, pos_bad, keep;
	bvs_pkg::ram_cmd_t             ram_cmd;
	logic signed [bvs_pkg::DW-1:0] rd_data;

	bvs_ram u_ram (
		.clk     (clk),
		.cmd     (ram_cmd),
		.rd_data (rd_data)
	);

	// The result register frees when it is empty or being taken this cycle.
	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE) || ((state_q == S_DONE) && out_free);
	assign acc       = req_valid && req_ready;
	assign full      = (count_q == bvs_pkg::COUNT_FULL);
	assign pos_bad   = (req.position >= count_q);
	assign lo_nx     = lo_q + 1'b1;
	assign hi_nx     = hi_q - 1'b1;
	assign keep      = vld_s1 && (rd_data != del_val_q);

	always_comb begin
		ram_cmd = '0;
		state_d = state_q;
		pend_d  = pend_q;

		case (state_q)
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_REV_HI: begin
				// lo word lands in rd_data now; fetch its partner
				ram_cmd.re    = 1'b1;
				ram_cmd.raddr = hi_q;
				state_d       = S_REV_WLO;
			end
			S_REV_WLO: begin
				ram_cmd.we    = 1'b1;
				ram_cmd.waddr = lo_q;
				ram_cmd.wdata = rd_data;
				state_d       = S_REV_WHI;
			end
			S_REV_WHI: begin
				ram_cmd.we    = 1'b1;
				ram_cmd.waddr = hi_q;
				ram_cmd.wdata = tmp_q;
				if (lo_nx < hi_nx) begin
					ram_cmd.re    = 1'b1;
					ram_cmd.raddr = lo_nx;
					state_d       = S_REV_HI;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DEL_SCAN: begin
				// Reads run ahead of compacting writes, so addresses never collide.
				if (rd_q != count_q) begin
					ram_cmd.re    = 1'b1;
					ram_cmd.raddr = rd_q[bvs_pkg::AW-1:0];
				end
				if (keep) begin
					ram_cmd.we    = 1'b1;
					ram_cmd.waddr = wr_q[bvs_pkg::AW-1:0];
					ram_cmd.wdata = rd_data;
				end
				if ((rd_q == count_q) && !vld_s1) begin
					state_d = S_DEL_FILL;
				end
			end
			S_DEL_FILL: begin
				if (wr_q != count_q) begin
					ram_cmd.we    = 1'b1;
					ram_cmd.waddr = wr_q[bvs_pkg::AW-1:0];
					ram_cmd.wdata = fill_q;
				end else begin
					state_d = S_DONE;
				end
			end
			default: begin
			end
		endcase

		// Accept happens only in IDLE or DONE, where the RAM is otherwise quiet.
		if (acc) begin
			pend_d.read_word = '0;
			pend_d.status    = bvs_pkg::ST_OK;
			pend_d.count_now = count_q;
			state_d          = S_DONE;
			case (req.operation)
				bvs_pkg::OP_PUSH: begin
					if (full) begin
						pend_d.status = bvs_pkg::ST_FULL;
					end else begin
						ram_cmd.we       = 1'b1;
						ram_cmd.waddr    = count_q[bvs_pkg::AW-1:0];
						ram_cmd.wdata    = req.word_in;
						pend_d.count_now = count_q + bvs_pkg::COUNT_ONE;
					end
				end
				bvs_pkg::OP_GET: begin
					if (pos_bad) begin
						pend_d.read_word = '1;
						pend_d.status    = bvs_pkg::ST_BAD_INDEX;
					end else begin
						ram_cmd.re    = 1'b1;
						ram_cmd.raddr = req.position[bvs_pkg::AW-1:0];
					end
				end
				bvs_pkg::OP_SET: begin
					if (pos_bad) begin
						pend_d.status = bvs_pkg::ST_BAD_INDEX;
					end else begin
						ram_cmd.we    = 1'b1;
						ram_cmd.waddr = req.position[bvs_pkg::AW-1:0];
						ram_cmd.wdata = req.word_in;
					end
				end
				bvs_pkg::OP_REVERSE: begin
					if (count_q > bvs_pkg::COUNT_ONE) begin
						ram_cmd.re    = 1'b1;
						ram_cmd.raddr = '0;
						state_d       = S_REV_HI;
					end
				end
				bvs_pkg::OP_DELETE: begin
					state_d = S_DEL_SCAN;
				end
				default: begin
				end
			endcase
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			fill_q      <= bvs_pkg::FILL_RESET;
			out_valid_q <= 1'b0;
			vld_s1      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) begin
				fill_q <= cfg_wdata;
			end
			if (acc && (req.operation == bvs_pkg::OP_PUSH) && !full) begin
				count_q <= count_q + bvs_pkg::COUNT_ONE;
			end
			if (acc) begin
				vld_s1 <= 1'b0;
			end else if (state_q == S_DEL_SCAN) begin
				vld_s1 <= (rd_q != count_q);
			end
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers, without reset; each is set up before it is used, most on accept.
	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		if (acc) begin
			get_ok_q  <= (req.operation == bvs_pkg::OP_GET) && !pos_bad;
			lo_q      <= '0;
			hi_q      <= count_q[bvs_pkg::AW-1:0] - 1'b1;
			rd_q      <= '0;
			wr_q      <= '0;
			del_val_q <= req.word_in;
		end else begin
			case (state_q)
				S_REV_HI: begin
					tmp_q <= rd_data;
				end
				S_REV_WHI: begin
					lo_q <= lo_nx;
					hi_q <= hi_nx;
				end
				S_DEL_SCAN: begin
					if (rd_q != count_q) begin
						rd_q <= rd_q + bvs_pkg::COUNT_ONE;
					end
					if (keep) begin
						wr_q <= wr_q + bvs_pkg::COUNT_ONE;
					end
				end
				S_DEL_FILL: begin
					if (wr_q != count_q) begin
						wr_q <= wr_q + bvs_pkg::COUNT_ONE;
					end
				end
				default: begin
				end
			endcase
		end
		// Load the result; a get takes its word from the RAM read issued on accept.
		if ((state_q == S_DONE) && out_free) begin
			out_q.read_word <= get_ok_q ? rd_data : pend_q.read_word;
			out_q.status    <= pend_q.status;
			out_q.count_now <= pend_q.count_now;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	`AST_CHECK(a_count_bound, clk, arst_n, count_q <= bvs_pkg::COUNT_FULL, "count above depth")
	`AST_NEVER(a_ram_collide, clk, arst_n, ram_cmd.we && ram_cmd.re && (ram_cmd.waddr == ram_cmd.raddr), "RAM read and write hit one entry")
	`AST_CHECK(a_done_loads, clk, arst_n, ((state_q == S_DONE) && out_free) |=> rsp_valid, "result not loaded")
	`AST_CHECK(a_rev_order, clk, arst_n, ((state_q == S_REV_HI) || (state_q == S_REV_WLO) || (state_q == S_REV_WHI)) |-> (lo_q < hi_q), "reverse pointers crossed")
	`AST_CHECK(a_del_order, clk, arst_n, ((state_q == S_DEL_SCAN) || (state_q == S_DEL_FILL)) |-> ((wr_q <= rd_q) && (rd_q <= count_q)), "delete pointers out of order")

endmodule
